/* rtl/vloc_pkg.sv */
package vloc_pkg;

    // Command codes carried in the input word.
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Largest value that fits in eight encoded bytes.
    localparam logic [55:0] VALUE_MAX = 56'hFF_FFFF_FFFF_FFFF;

    // Bits of value carried by one encoded byte.
    localparam int BITS_PER_BYTE = 7;

    // Input word.
    typedef struct packed {
        logic        command;
        logic [63:0] value;
        logic [7:0]  in_byte;
    } t_in_item;

    // Result word.
    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  out_byte;
        logic [55:0] out_value;
        logic [3:0]  byte_count;
        logic        last;
    } t_out_item;

endpackage

/* rtl/vloc_encode.sv */
module vloc_encode
    import vloc_pkg::*;
(
    input  logic [63:0] i_value,
    input  logic [2:0]  i_idx,
    output t_out_item   o_result
);

    logic        too_large;
    logic [3:0]  len;
    logic [2:0]  extra;
    logic [2:0]  sel;
    logic [55:0] shifted;
    logic [7:0]  prefix;
    logic [7:0]  data_byte;

    // Encoded length: one byte plus one for each 7-bit group above the first.
    always_comb begin
        len = 4'd1;
        for (int k = 1; k < 8; k++) begin
            if ((i_value >> (BITS_PER_BYTE * k)) != 64'd0) begin
                len = len + 4'd1;
            end
        end
    end

    assign too_large = (i_value[63:56] != 8'd0);
    assign extra     = len[2:0] - 3'd1;

    // Byte i of the encoding is the value shifted down by 8 * (extra - i).
    assign sel     = extra - i_idx;
    assign shifted = i_value[55:0] >> {sel, 3'b000};
    assign prefix  = ~(8'hFF >> extra);

    always_comb begin
        if (i_idx == 3'd0) begin
            data_byte = prefix | shifted[7:0];
        end else begin
            data_byte = shifted[7:0];
        end
    end

    // Result word for the selected byte, or a single error word.
    always_comb begin
        o_result = '0;
        if (too_large) begin
            o_result.out_kind = KIND_ERROR;
            o_result.last     = 1'b1;
        end else begin
            o_result.out_kind   = KIND_BYTE;
            o_result.out_byte   = data_byte;
            o_result.byte_count = len;
            o_result.last       = (i_idx == extra);
        end
    end

endmodule

/* rtl/vloc_decode.sv */
module vloc_decode
    import vloc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  logic [7:0] i_byte,
    output logic      o_has_result,
    output t_out_item o_result
);

    logic        r_active;
    logic [2:0]  r_remaining;
    logic [55:0] r_accum;
    logic [3:0]  r_total;

    logic        n_active;
    logic [2:0]  n_remaining;
    logic [55:0] n_accum;
    logic [3:0]  n_total;

    logic [3:0]  ones;
    logic        run;
    logic [7:0]  low_mask;
    logic [55:0] shifted_accum;
    logic [2:0]  remaining_dec;

    // Count the leading one bits of the first byte.
    always_comb begin
        ones = 4'd0;
        run  = 1'b1;
        for (int k = 7; k >= 0; k--) begin
            if (run && i_byte[k]) begin
                ones = ones + 4'd1;
            end else begin
                run = 1'b0;
            end
        end
    end

    assign low_mask      = 8'h7F >> ones[2:0];
    assign shifted_accum = {r_accum[47:0], i_byte};
    assign remaining_dec = r_remaining - 3'd1;

    // Next state and the result, if this byte produces one.
    always_comb begin
        n_active     = r_active;
        n_remaining  = r_remaining;
        n_accum      = r_accum;
        n_total      = r_total;
        o_has_result = 1'b0;
        o_result     = '0;
        o_result.last = 1'b1;
        if (!r_active) begin
            if (ones[3]) begin
                // A first byte of all ones is not a valid prefix.
                o_has_result      = 1'b1;
                o_result.out_kind = KIND_ERROR;
            end else if (ones == 4'd0) begin
                // Single-byte encoding finishes right away.
                o_has_result        = 1'b1;
                o_result.out_kind   = KIND_VALUE;
                o_result.out_value  = {48'd0, i_byte & low_mask};
                o_result.byte_count = 4'd1;
                n_accum             = '0;
                n_total             = '0;
            end else begin
                n_accum     = {48'd0, i_byte & low_mask};
                n_total     = ones + 4'd1;
                n_remaining = ones[2:0];
                n_active    = 1'b1;
            end
        end else begin
            n_remaining = remaining_dec;
            if (remaining_dec == 3'd0) begin
                o_has_result        = 1'b1;
                o_result.out_kind   = KIND_VALUE;
                o_result.out_value  = shifted_accum;
                o_result.byte_count = r_total;
                n_active            = 1'b0;
                n_accum             = '0;
                n_total             = '0;
            end else begin
                n_accum = shifted_accum;
            end
        end
    end

    // Decoder state advances only when a decode word is consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_remaining <= '0;
            r_accum     <= '0;
            r_total     <= '0;
        end else if (i_step) begin
            r_active    <= n_active;
            r_remaining <= n_remaining;
            r_accum     <= n_accum;
            r_total     <= n_total;
        end
    end

endmodule

/* rtl/varint_leading_ones_codec.sv */
// Channel | Direction | Handshake               | Word
// input   | in        | i_in_valid / o_in_ready  | i_in  (t_in_item)
// output  | out       | o_out_valid / i_out_ready | o_out (t_out_item)
//
// A new decode byte can be accepted every cycle while the output can take its
// result or the byte produces none. An encode word holds the input register
// until its encoded bytes (1 to 8) or its error word for a too-large value
// are sent, counted by the byte counter; results come from the output register.
// Reset is synchronous and clears the decoder and all valid flags.
// A stalled output holds its word while the input register keeps working
// on decode bytes that produce no result.
module varint_leading_ones_codec
    import vloc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic [2:0] r_idx;
    logic      r_out_valid;
    t_out_item r_out;

    logic      enc_sel;
    logic      has_res;
    logic      out_free;
    logic      step;
    logic      done;
    logic      dec_has;
    t_out_item enc_res;
    t_out_item dec_res;
    t_out_item stage_res;

    vloc_encode u_encode (
        .i_value  (r_in.value),
        .i_idx    (r_idx),
        .o_result (enc_res)
    );

    vloc_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step && !enc_sel),
        .i_byte       (r_in.in_byte),
        .o_has_result (dec_has),
        .o_result     (dec_res)
    );

    // The held word advances when the output can take its result,
    // or at once when it produces none.
    assign enc_sel   = (r_in.command == CMD_ENCODE);
    assign has_res   = enc_sel ? 1'b1 : dec_has;
    assign stage_res = enc_sel ? enc_res : dec_res;
    assign out_free  = !r_out_valid || i_out_ready;
    assign step      = r_in_valid && (out_free || !has_res);
    assign done      = step && (!enc_sel || enc_res.last);
    assign o_in_ready = !r_in_valid || done;

    // Input register and encode byte counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_idx      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (done) begin
                r_idx <= '0;
            end else if (step && enc_sel) begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && has_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && has_res) begin
            r_out <= stage_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* verif/tb_varint_leading_ones_codec.sv */
`timescale 1ns / 1ps

module tb_varint_leading_ones_codec
    import vloc_pkg::*;
();

    localparam int CLK_HALF     = 6;
    localparam int HOLD_CYCLES  = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int RUN_LIMIT_NS = 2_000_000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out;

    varint_leading_ones_codec uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // Words waiting to be offered, and results the codec still owes us.
    t_in_item  pending_words[$];
    t_out_item expected_results[$];

    // Traffic shaping, set by the stimulus process between phases.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;

    logic word_taken = 1'b0;
    int   mismatch_count = 0;

    // Private copy of the decoder state.
    logic        dec_active = 1'b0;
    logic [2:0]  dec_left = '0;
    logic [55:0] dec_acc = '0;
    logic [3:0]  dec_total = '0;

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic push_result(input logic [1:0] kind, input logic [7:0] byte_val,
                               input logic [55:0] val, input logic [3:0] count,
                               input logic is_last);
        t_out_item r;
        r.out_kind   = kind;
        r.out_byte   = byte_val;
        r.out_value  = val;
        r.byte_count = count;
        r.last       = is_last;
        expected_results.push_back(r);
    endtask

    // Work out the results one accepted word causes and advance the decoder copy.
    task automatic predict_codec(input t_in_item w);
        int unsigned n;
        int unsigned ones;
        logic [7:0]  b;
        logic [7:0]  first;
        logic [7:0]  low;
        if (w.command == CMD_ENCODE) begin
            if (w.value > {8'h00, VALUE_MAX}) begin
                push_result(KIND_ERROR, 8'h00, '0, 4'd0, 1'b1);
            end else begin
                n = 1;
                while (n < 8 && (w.value >> (BITS_PER_BYTE * n)) != 64'd0) n++;
                first = 8'hFF << (9 - n);
                first = first | w.value[8 * (n - 1) +: 8];
                push_result(KIND_BYTE, first, '0, n[3:0], n == 1);
                for (int i = 1; i < n; i++) begin
                    push_result(KIND_BYTE, w.value[8 * (n - 1 - i) +: 8], '0, n[3:0],
                                i == n - 1);
                end
            end
        end else begin
            b = w.in_byte;
            if (!dec_active) begin
                ones = 0;
                while (ones < 8 && b[7 - ones]) ones++;
                if (ones == 8) begin
                    // A first byte of all ones has no legal length.
                    push_result(KIND_ERROR, 8'h00, '0, 4'd0, 1'b1);
                end else begin
                    low = 8'hFF >> (ones + 1);
                    low = low & b;
                    dec_acc = {48'd0, low};
                    dec_total = 4'(ones + 1);
                    if (ones == 0) begin
                        push_result(KIND_VALUE, 8'h00, dec_acc, 4'd1, 1'b1);
                        dec_acc = '0;
                        dec_total = '0;
                    end else begin
                        dec_left = 3'(ones);
                        dec_active = 1'b1;
                    end
                end
            end else begin
                dec_acc = {dec_acc[47:0], b};
                dec_left = dec_left - 3'd1;
                if (dec_left == 3'd0) begin
                    push_result(KIND_VALUE, 8'h00, dec_acc, dec_total, 1'b1);
                    dec_active = 1'b0;
                    dec_acc = '0;
                    dec_total = '0;
                end
            end
        end
    endtask

    // Sender: offer the next word at the falling edge, hold it until accepted.
    always @(negedge i_clk) begin
        if (i_in_valid && !word_taken) begin
            i_in_valid <= 1'b1;
        end else if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            i_in       <= pending_words.pop_front();
            i_in_valid <= 1'b1;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            i_out_ready <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on every accepted input word, check every accepted result word.
    always @(posedge i_clk) begin
        t_out_item want;
        word_taken <= i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) predict_codec(i_in);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result word", 64'(o_out), 64'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_out.out_kind !== want.out_kind)
                    report_mismatch("out_kind", 64'(o_out.out_kind), 64'(want.out_kind));
                if (o_out.out_byte !== want.out_byte)
                    report_mismatch("out_byte", 64'(o_out.out_byte), 64'(want.out_byte));
                if (o_out.out_value !== want.out_value)
                    report_mismatch("out_value", 64'(o_out.out_value), 64'(want.out_value));
                if (o_out.byte_count !== want.byte_count)
                    report_mismatch("byte_count", 64'(o_out.byte_count),
                                    64'(want.byte_count));
                if (o_out.last !== want.last)
                    report_mismatch("last", 64'(o_out.last), 64'(want.last));
            end
        end
    end

    task automatic queue_encode(input logic [63:0] v);
        t_in_item w;
        w.command = CMD_ENCODE;
        w.value   = v;
        w.in_byte = 8'($urandom);
        pending_words.push_back(w);
    endtask

    task automatic queue_decode(input logic [7:0] b);
        t_in_item w;
        w.command = CMD_DECODE;
        w.value   = {$urandom, $urandom};
        w.in_byte = b;
        pending_words.push_back(w);
    endtask

    // A random encode value of a given encoded length, often at a length boundary.
    function automatic logic [63:0] value_of_length(input int unsigned n);
        logic [63:0] v;
        v = {$urandom, $urandom} & ((64'd1 << (BITS_PER_BYTE * n)) - 64'd1);
        case ($urandom_range(3))
            0: v = (64'd1 << (BITS_PER_BYTE * n)) - 64'd1;
            1: v = (n == 1) ? 64'd0 : (64'd1 << (BITS_PER_BYTE * (n - 1)));
            default: v = v | ((n == 1) ? 64'd0 : (64'd1 << (BITS_PER_BYTE * (n - 1))));
        endcase
        return v;
    endfunction

    // A well-formed encoding with random content, sometimes with encodes mixed in.
    task automatic queue_decode_sequence(input int unsigned n);
        logic [7:0] first;
        logic [7:0] low;
        first = 8'hFF << (9 - n);
        low   = 8'hFF >> n;
        low   = low & 8'($urandom);
        queue_decode(first | low);
        for (int i = 1; i < n; i++) begin
            if ($urandom_range(9) == 0) queue_encode(value_of_length($urandom_range(8, 1)));
            queue_decode(($urandom_range(7) == 0) ? 8'hFF : 8'($urandom));
        end
    endtask

    task automatic queue_random_mix(input int unsigned count);
        int unsigned target;
        int unsigned pick;
        target = pending_words.size() + count;
        while (pending_words.size() < target) begin
            pick = $urandom_range(99);
            if (pick < 40)
                queue_encode(value_of_length($urandom_range(8, 1)));
            else if (pick < 45)
                queue_encode({$urandom, $urandom} | (64'd1 << $urandom_range(63, 56)));
            else if (pick < 88)
                queue_decode_sequence($urandom_range(8, 1));
            else if (pick < 93)
                queue_decode(8'hFF);
            else
                queue_decode(8'($urandom));
        end
    endtask

    task automatic set_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Let every queued word go in and every owed result come out.
    task automatic wait_all_done();
        while (pending_words.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
            #1;
        end
        repeat (SETTLE_CYCLES) begin
            @(posedge i_clk);
            #1;
        end
    endtask

    // Stimulus: directed words, then random phases under different traffic.
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        #1;

        // Encode at the 1/2, 2/3 and 7/8 length boundaries and both sides of the size limit.
        set_traffic(0, 0);
        queue_encode(64'd0);
        queue_encode(64'h7F);
        queue_encode(64'h80);
        queue_encode(64'h3FFF);
        queue_encode(64'h4000);
        queue_encode(64'h0001_FFFF_FFFF_FFFF);
        queue_encode(64'h0002_0000_0000_0000);
        queue_encode(64'h00FF_FFFF_FFFF_FFFF);
        queue_encode(64'h0100_0000_0000_0000);
        queue_encode(64'hFFFF_FFFF_FFFF_FFFF);
        // Single-byte decodes and the all-ones first byte.
        queue_decode(8'h00);
        queue_decode(8'h7F);
        queue_decode(8'hFF);
        // Two-byte decode of zero.
        queue_decode(8'h80);
        queue_decode(8'h00);
        // Longest decode with all-ones data bytes and an encode in the middle.
        queue_decode(8'hFE);
        for (int i = 0; i < 7; i++) begin
            if (i == 3) queue_encode(64'h1234);
            queue_decode(8'hFF);
        end
        // Non-minimal three-byte encoding of a small value.
        queue_decode(8'hC0);
        queue_decode(8'h00);
        queue_decode(8'h05);
        wait_all_done();

        set_traffic(0, 0);
        queue_random_mix(50);
        wait_all_done();

        set_traffic(52, 0);
        queue_random_mix(50);
        wait_all_done();

        set_traffic(0, 52);
        queue_random_mix(50);
        wait_all_done();

        set_traffic(18, 18);
        queue_random_mix(40);
        wait_all_done();

        // Hold the output off for a long stretch while words keep coming.
        set_traffic(0, 0);
        hold_requests = hold_requests + 1;
        queue_random_mix(25);
        wait_all_done();

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/vloc_pkg.sv
rtl/vloc_encode.sv
rtl/vloc_decode.sv
rtl/varint_leading_ones_codec.sv
verif/tb_varint_leading_ones_codec.sv
